/* src/fra_pkg.sv */
// Package for the four-register ALU with divide.
// Holds widths, register indexes, opcodes, sequencer states and divider structs.
// No dependencies; used by every other file in src.
package fra_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam int KIND_W    = 3;
  localparam int VIS_REGS  = 1 << REG_IDX_W;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [REG_IDX_W-1:0] ACC_IDX = 2'd0;
  localparam logic [REG_IDX_W-1:0] REM_IDX = 2'd3;

  localparam logic [DATA_W-1:0] DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] DATA_ONES = {DATA_W{1'b1}};

  // Instruction opcodes; codes 5..7 are no-ops
  typedef enum logic [KIND_W-1:0] {
    KIND_MOV = 3'd0,
    KIND_ADD = 3'd1,
    KIND_SUB = 3'd2,
    KIND_MUL = 3'd3,
    KIND_DIV = 3'd4
  } fra_kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL_WB,
    ST_DIV_WAIT,
    ST_OUT
  } fra_state_t;

  // Start request to the shared divider (unsigned magnitudes)
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } fra_div_req_t;

  // Divider completion
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } fra_div_resp_t;

endpackage

/* src/fra_if.sv */
// Valid/ready channel interfaces for the four-register ALU.
// Depends on fra_pkg for field widths.
interface fra_in_if;
  logic                               valid;
  logic                               ready;
  logic [fra_pkg::KIND_W-1:0]         kind;
  logic                               use_immediate;
  logic [fra_pkg::REG_IDX_W-1:0]      dest_reg;
  logic [fra_pkg::REG_IDX_W-1:0]      src_reg;
  logic signed [fra_pkg::DATA_W-1:0]  immediate;

  modport source (output valid, kind, use_immediate, dest_reg, src_reg, immediate,
                  input ready);
  modport sink   (input valid, kind, use_immediate, dest_reg, src_reg, immediate,
                  output ready);
endinterface

interface fra_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fra_pkg::DATA_W-1:0]  reg_a;
  logic signed [fra_pkg::DATA_W-1:0]  reg_b;
  logic signed [fra_pkg::DATA_W-1:0]  reg_c;
  logic signed [fra_pkg::DATA_W-1:0]  reg_d;
  logic                               divide_error;

  modport source (output valid, reg_a, reg_b, reg_c, reg_d, divide_error, input ready);
  modport sink   (input valid, reg_a, reg_b, reg_c, reg_d, divide_error, output ready);
endinterface

/* src/fra_div.sv */
// Iterative radix-2 restoring divider, one quotient bit per cycle.
// Unsigned operands; depends on fra_pkg for widths and request/response structs.
module fra_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fra_pkg::fra_div_req_t  req,
  output fra_pkg::fra_div_resp_t resp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [fra_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fra_pkg::DATA_W-1:0]      rem_r, rem_nxt;
  logic [fra_pkg::DATA_W-1:0]      quo_r, quo_nxt;
  logic [fra_pkg::DATA_W-1:0]      dvs_r, dvs_nxt;

  logic [fra_pkg::DATA_W:0]        shifted;
  logic [fra_pkg::DATA_W:0]        diff;
  logic                            fits;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_r, quo_r[fra_pkg::DATA_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = ~diff[fra_pkg::DATA_W];
  end

  // Step sequencing; quotient register doubles as dividend shifter
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[fra_pkg::DATA_W-1:0] : shifted[fra_pkg::DATA_W-1:0];
      quo_nxt = {quo_r[fra_pkg::DATA_W-2:0], fits};
      cnt_nxt = cnt_r + fra_pkg::DIV_CNT_W'(1);
      if (cnt_r == {fra_pkg::DIV_CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign resp.done      = done_r;
  assign resp.quotient  = quo_r;
  assign resp.remainder = rem_r;

endmodule

/* src/four_register_alu_with_divide.sv */
// Top level: four-register ALU with sequencer, register file and shared divider.
// Depends on fra_pkg, fra_if (fra_in_if, fra_out_if) and fra_div.
//
//   channel  | direction | handshake   | payload
//   ---------+-----------+-------------+--------------------------------------------------
//   in_ch    | in        | valid/ready | kind, use_immediate, dest_reg, src_reg, immediate
//   out_ch   | out       | valid/ready | reg_a..reg_d, divide_error
//
// One instruction at a time; in_ch.ready is high only in ST_IDLE.
// From accept, move/add/subtract/no-op and a refused divide go ST_EXEC, then ST_OUT;
// multiply goes ST_EXEC, ST_MUL_WB (product registered before writeback), then ST_OUT;
// divide goes ST_EXEC (setup), ST_DIV_WAIT (single-bit steps of the shared divider
// until its done strobe), then ST_OUT.
// Output waits in ST_OUT until taken. Sync active-low reset clears registers and sequencer.
module four_register_alu_with_divide (
  input  logic       clk,
  input  logic       rst_n,
  fra_in_if.sink     in_ch,
  fra_out_if.source  out_ch
);

  fra_pkg::fra_state_t                state_r, state_nxt;
  logic [fra_pkg::DATA_W-1:0]         rf_r   [fra_pkg::VIS_REGS];
  logic [fra_pkg::DATA_W-1:0]         rf_nxt [fra_pkg::VIS_REGS];

  logic [fra_pkg::KIND_W-1:0]         kind_r;
  logic                               use_imm_r;
  logic [fra_pkg::REG_IDX_W-1:0]      dst_r;
  logic [fra_pkg::REG_IDX_W-1:0]      src_r;
  logic [fra_pkg::DATA_W-1:0]         imm_r;
  logic [fra_pkg::DATA_W-1:0]         prod_r, prod_nxt;
  logic                               err_r, err_nxt;
  logic                               neg_q_r, neg_q_nxt;
  logic                               neg_rem_r, neg_rem_nxt;

  logic                               in_fire;
  logic [fra_pkg::DATA_W-1:0]         operand;
  logic [fra_pkg::DATA_W-1:0]         acc;
  logic                               div_bad;
  fra_pkg::fra_div_req_t              div_req;
  fra_pkg::fra_div_resp_t             div_resp;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign operand = use_imm_r ? imm_r : rf_r[src_r];
  assign acc     = rf_r[fra_pkg::ACC_IDX];
  assign div_bad = (operand == '0) ||
                   ((acc == fra_pkg::DATA_MIN) && (operand == fra_pkg::DATA_ONES));

  // Shared divider
  fra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fra_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = fra_pkg::ST_EXEC;
      end
      fra_pkg::ST_EXEC: begin
        case (fra_pkg::fra_kind_t'(kind_r))
          fra_pkg::KIND_MUL: state_nxt = fra_pkg::ST_MUL_WB;
          fra_pkg::KIND_DIV: state_nxt = div_bad ? fra_pkg::ST_OUT : fra_pkg::ST_DIV_WAIT;
          default:           state_nxt = fra_pkg::ST_OUT;
        endcase
      end
      fra_pkg::ST_MUL_WB: state_nxt = fra_pkg::ST_OUT;
      fra_pkg::ST_DIV_WAIT: begin
        if (div_resp.done) state_nxt = fra_pkg::ST_OUT;
      end
      fra_pkg::ST_OUT: begin
        if (out_ch.ready) state_nxt = fra_pkg::ST_IDLE;
      end
      default: state_nxt = fra_pkg::ST_IDLE;
    endcase
  end

  // Outputs and divider start
  always_comb begin
    in_ch.ready         = (state_r == fra_pkg::ST_IDLE);
    out_ch.valid        = (state_r == fra_pkg::ST_OUT);
    out_ch.reg_a        = rf_r[0];
    out_ch.reg_b        = rf_r[1];
    out_ch.reg_c        = rf_r[2];
    out_ch.reg_d        = rf_r[3];
    out_ch.divide_error = err_r;
    div_req.start       = (state_r == fra_pkg::ST_EXEC) &&
                          (fra_pkg::fra_kind_t'(kind_r) == fra_pkg::KIND_DIV) && !div_bad;
    div_req.dividend    = acc[fra_pkg::DATA_W-1] ? (fra_pkg::DATA_W'(0) - acc) : acc;
    div_req.divisor     = operand[fra_pkg::DATA_W-1] ? (fra_pkg::DATA_W'(0) - operand)
                                                      : operand;
  end

  // Execute-stage bookkeeping: error flag, signs, product
  always_comb begin
    err_nxt     = err_r;
    neg_q_nxt   = neg_q_r;
    neg_rem_nxt = neg_rem_r;
    prod_nxt    = prod_r;
    if (state_r == fra_pkg::ST_EXEC) begin
      err_nxt     = (fra_pkg::fra_kind_t'(kind_r) == fra_pkg::KIND_DIV) && div_bad;
      neg_q_nxt   = acc[fra_pkg::DATA_W-1] ^ operand[fra_pkg::DATA_W-1];
      neg_rem_nxt = acc[fra_pkg::DATA_W-1];
      prod_nxt    = acc * operand;
    end
  end

  // Register file writeback
  always_comb begin
    rf_nxt = rf_r;
    case (state_r)
      fra_pkg::ST_EXEC: begin
        case (fra_pkg::fra_kind_t'(kind_r))
          fra_pkg::KIND_MOV: rf_nxt[dst_r] = operand;
          fra_pkg::KIND_ADD: rf_nxt[dst_r] = rf_r[dst_r] + operand;
          fra_pkg::KIND_SUB: rf_nxt[dst_r] = rf_r[dst_r] - operand;
          default: ;
        endcase
      end
      fra_pkg::ST_MUL_WB: rf_nxt[fra_pkg::ACC_IDX] = prod_r;
      fra_pkg::ST_DIV_WAIT: begin
        if (div_resp.done) begin
          rf_nxt[fra_pkg::ACC_IDX] = neg_q_r ? (fra_pkg::DATA_W'(0) - div_resp.quotient)
                                             : div_resp.quotient;
          rf_nxt[fra_pkg::REM_IDX] = neg_rem_r ? (fra_pkg::DATA_W'(0) - div_resp.remainder)
                                               : div_resp.remainder;
        end
      end
      default: ;
    endcase
  end

  // Control state and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fra_pkg::ST_IDLE;
      err_r   <= 1'b0;
      for (int i = 0; i < fra_pkg::VIS_REGS; i++) rf_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
      rf_r    <= rf_nxt;
    end
  end

  // Instruction latch and execute payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= in_ch.kind;
      use_imm_r <= in_ch.use_immediate;
      dst_r     <= in_ch.dest_reg;
      src_r     <= in_ch.src_reg;
      imm_r     <= in_ch.immediate;
    end
    prod_r    <= prod_nxt;
    neg_q_r   <= neg_q_nxt;
    neg_rem_r <= neg_rem_nxt;
  end

endmodule

/* src/fra_checker.sv */
// Port-level checker for the four-register ALU, bound to the top level.
// Depends on fra_pkg for widths and opcodes.
module fra_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [fra_pkg::KIND_W-1:0]    in_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_divide_error
);

  logic                        in_fire;
  logic                        out_fire;
  logic [fra_pkg::KIND_W-1:0]  kind_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Opcode of the transaction in flight
  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= '0;
    else if (in_fire) kind_r <= in_kind;
  end

  // Result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before handshake");

  // One transaction at a time: no new input while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // After accepting an instruction, input closes and no result is offered right away
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready && !out_valid)
    else $error("block not busy after accept");

  // A taken result is not offered again right after its handshake
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> !out_valid)
    else $error("repeated result");

  // Error flag only comes from a divide
  a_err_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> kind_r == fra_pkg::KIND_DIV)
    else $error("divide_error on a non-divide instruction");

endmodule

bind four_register_alu_with_divide fra_checker u_fra_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_kind          (in_ch.kind),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_divide_error (out_ch.divide_error)
);
